// ----- design/ppef_pkg.sv -----
// Shared constants, types and a helper function for the pair energy and force pipeline.
`default_nettype none
package ppef_pkg;

  // Default fixed-point formats.
  localparam int IN_FRAC_DEF  = 16;
  localparam int OUT_FRAC_DEF = 16;

  // Register reset values and register indexes (taken from paddr bit 2).
  localparam logic [15:0] EPS_RESET = 16'd4295;
  localparam logic        REG_MODE  = 1'b0;
  localparam logic        REG_EPS   = 1'b1;

  // Status codes.
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FAR  = 2'd1;
  localparam logic [1:0] STAT_ZERO = 2'd2;
  localparam logic [1:0] STAT_SAT  = 2'd3;

  // Fixed constants.
  localparam logic [31:0] HALF_PI_Q31 = 32'd3373259426;
  localparam logic [32:0] HALF_PI_Q32 = 33'd6746518852;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] MAG_LIM     = 64'd1 << 63;
  localparam logic [63:0] R_LIM       = 64'd1 << 48;
  localparam logic [63:0] Q_LIM       = 64'd1 << 62;

  // Pipeline stage numbers (register index after each step).
  localparam int STG_SUM  = 2;
  localparam int STG_D    = 35;
  localparam int STG_T    = 36;
  localparam int STG_U    = 37;
  localparam int STG_SER  = 38;
  localparam int STG_Q    = 128;
  localparam int STG_MRG  = 133;
  localparam int STG_EN   = 134;
  localparam int STG_FQ   = 199;
  localparam int STG_OUT  = 200;

  // Horner divisors: row 0 sine, row 1 cosine, step 0 first (highest power).
  localparam logic [8:0] K_TAB [2][8] = '{
    '{9'd272, 9'd210, 9'd156, 9'd110, 9'd72, 9'd42, 9'd20, 9'd6},
    '{9'd240, 9'd182, 9'd132, 9'd90,  9'd56, 9'd30, 9'd12, 9'd2}
  };

  // Reciprocals floor(2^40 / k) for the constant divisions above.
  localparam logic [39:0] M_TAB [2][8] = '{
    '{40'((64'd1 << 40) / 64'd272), 40'((64'd1 << 40) / 64'd210),
      40'((64'd1 << 40) / 64'd156), 40'((64'd1 << 40) / 64'd110),
      40'((64'd1 << 40) / 64'd72),  40'((64'd1 << 40) / 64'd42),
      40'((64'd1 << 40) / 64'd20),  40'((64'd1 << 40) / 64'd6)},
    '{40'((64'd1 << 40) / 64'd240), 40'((64'd1 << 40) / 64'd182),
      40'((64'd1 << 40) / 64'd132), 40'((64'd1 << 40) / 64'd90),
      40'((64'd1 << 40) / 64'd56),  40'((64'd1 << 40) / 64'd30),
      40'((64'd1 << 40) / 64'd12),  40'((64'd1 << 40) / 64'd2)}
  };

  // Side data that travels with each beat down the pipeline.
  typedef struct packed {
    logic [2:0][17:0] ax;
    logic [2:0]       xneg;
    logic             far;
    logic             zero;
    logic [31:0]      d;
    logic [32:0]      t;
    logic [31:0]      u;
    logic [31:0]      en;
    logic             esat;
    logic             fneg;
  } side_t;

  // Clamp a sign and magnitude to 32-bit two's complement; bit 32 flags saturation.
  function automatic logic [32:0] pack32(input logic neg, input logic [63:0] mag);
    logic [32:0] res;
    if (!neg) begin
      if (mag > 64'h7FFF_FFFF) res = {1'b1, 32'h7FFF_FFFF};
      else                     res = {1'b0, mag[31:0]};
    end else begin
      if (mag > 64'h8000_0000) res = {1'b1, 32'h8000_0000};
      else                     res = {1'b0, 32'd0 - mag[31:0]};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- design/ppef_div.sv -----
// Pipelined 128 by 64 bit restoring divider, one quotient bit per stage.
`default_nettype none
module ppef_div (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] hi,
  input  wire logic [63:0] lo,
  input  wire logic [63:0] den,
  output logic [63:0]      q
);

  // Stage 0 holds the operands, stages 1..64 each retire one quotient bit.
  logic [63:0] rem_r [0:64];
  logic [63:0] lq_r  [0:64];
  logic [63:0] den_r [0:64];
  logic        ovf_r [0:64];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= hi;
      lq_r[0]  <= lo;
      den_r[0] <= den;
      ovf_r[0] <= (hi >= den);
      for (int k = 1; k <= 64; k++) begin
        // Shift one dividend bit into the remainder and try a subtraction.
        if (rem_r[k-1][63] || ({rem_r[k-1][62:0], lq_r[k-1][63]} >= den_r[k-1])) begin
          rem_r[k] <= {rem_r[k-1][62:0], lq_r[k-1][63]} - den_r[k-1];
          lq_r[k]  <= {lq_r[k-1][62:0], 1'b1};
        end else begin
          rem_r[k] <= {rem_r[k-1][62:0], lq_r[k-1][63]};
          lq_r[k]  <= {lq_r[k-1][62:0], 1'b0};
        end
        den_r[k] <= den_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  // A quotient that does not fit, or a zero divisor, reads as all ones.
  assign q = ovf_r[64] ? '1 : lq_r[64];

endmodule
`default_nettype wire

// ----- design/particle_pair_energy_force.sv -----
// Top level: fully pipelined pair energy and force kernel with an APB register port.
//
// Input beats on in_* carry one displacement (x, y, z) each; output beats on out_*
// carry energy and force components in tdata and the status code in tuser.
// The pipeline accepts one beat per cycle while the output side does not stall.
// Most of its depth lies in the 32-step square root, the 24-stage sine and cosine
// series and two rows of 65-stage dividers (one for energy and force scalar, one
// for the three force components).
// Every stage advances together: when the output register holds an untaken beat,
// the whole pipeline holds and in_tready drops, so nothing is lost or repeated.
// Bubbles in the stream are carried as invalid stages and cost nothing.
// Reset clears all valid bits and loads energy_mode = 0 and epsilon = 4295.
// Registers: energy_mode at byte address 0, epsilon at byte address 4. They are
// written in the APB access cycle and read back on cfg_prdata; pready is always
// high. Registers should only be changed while no beat is in flight.
`default_nettype none
module particle_pair_energy_force #(
  parameter int IN_FRAC_BITS  = ppef_pkg::IN_FRAC_DEF,
  parameter int OUT_FRAC_BITS = ppef_pkg::OUT_FRAC_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [55:0]  in_tdata,    // disp_x, disp_y, disp_z, zero fill
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata,   // energy, force_x, force_y, force_z
  output logic [1:0]        out_tuser,   // status
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int GB   = 32 + OUT_FRAC_BITS - IN_FRAC_BITS;
  localparam int LAST = ppef_pkg::STG_OUT;
  localparam logic [63:0] KG = (GB >= 32) ? (64'(ppef_pkg::HALF_PI_Q32) << (GB - 32))
                                          : (64'(ppef_pkg::HALF_PI_Q32) >> (32 - GB));

  // Configuration registers.
  logic        mode_r;
  logic [15:0] eps_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      eps_r  <= ppef_pkg::EPS_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        ppef_pkg::REG_MODE: mode_r <= cfg_pwdata[0];
        ppef_pkg::REG_EPS:  eps_r  <= cfg_pwdata[15:0];
        default:            mode_r <= mode_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      ppef_pkg::REG_MODE: cfg_prdata = {31'd0, mode_r};
      ppef_pkg::REG_EPS:  cfg_prdata = {16'd0, eps_r};
      default:            cfg_prdata = '0;
    endcase
  end

  // Global advance: the pipeline moves unless the output beat is stalled.
  logic [LAST:0] vld_r;
  logic          adv;

  assign adv        = !vld_r[LAST] || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = vld_r[LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[LAST-1:0], in_tvalid};
  end

  // Input unpacking into magnitudes and signs.
  ppef_pkg::side_t side_in;
  always_comb begin
    side_in = '0;
    for (int i = 0; i < 3; i++) begin
      side_in.xneg[i] = in_tdata[18*i+17];
      side_in.ax[i]   = in_tdata[18*i+17] ? 18'(18'd0 - in_tdata[18*i +: 18])
                                          : in_tdata[18*i +: 18];
    end
  end

  // Side data, squares and sum.
  ppef_pkg::side_t side_r [0:LAST-1];
  logic [34:0] sq_r [3];
  logic [36:0] sum_r;
  logic [36:0] sum_c;

  assign sum_c = 37'(sq_r[0]) + 37'(sq_r[1]) + 37'(sq_r[2]);

  // Square root iterations.
  logic [63:0] sqv_r [32];
  logic [63:0] sqr_r [32];
  logic [63:0] sqv_nxt [32];
  logic [63:0] sqr_nxt [32];

  always_comb begin
    logic [63:0] vi, ri, bt, rb;
    for (int i = 0; i < 32; i++) begin
      if (i == 0) begin
        vi = 64'(sum_r) << (64 - 2 * IN_FRAC_BITS);
        ri = '0;
      end else begin
        vi = sqv_r[i-1];
        ri = sqr_r[i-1];
      end
      bt = 64'd1 << (62 - 2 * i);
      rb = ri + bt;
      if (vi >= rb) begin
        sqv_nxt[i] = vi - rb;
        sqr_nxt[i] = (ri >> 1) + bt;
      end else begin
        sqv_nxt[i] = vi;
        sqr_nxt[i] = ri >> 1;
      end
    end
  end

  // Angle t and its square.
  logic [63:0] tprod_r;
  logic [65:0] tt_r;
  logic [32:0] t_c;
  assign t_c = tprod_r[63:31];

  // Horner series: index 0 sine, 1 cosine.
  logic [31:0] sp_r  [8][2];
  logic [31:0] spp_r [8][2];
  logic [31:0] sq0_r [8][2];
  logic [30:0] srr_r [8][2];

  always_ff @(posedge clk) begin
    logic [63:0] rin;
    logic [63:0] pr;
    logic [71:0] qm;
    logic [40:0] qk;
    logic [31:0] rem, m;
    if (adv) begin
      for (int j = 0; j < 8; j++) begin
        for (int c = 0; c < 2; c++) begin
          // Multiply stage.
          rin = (j == 0) ? ppef_pkg::ONE_Q30 : 64'(srr_r[(j == 0) ? 0 : j-1][c]);
          pr  = 64'(side_r[ppef_pkg::STG_U + 3*j].u) * rin;
          sp_r[j][c] <= pr[61:30];
          // Reciprocal estimate stage.
          qm = 72'(sp_r[j][c]) * 72'(ppef_pkg::M_TAB[c][j]);
          sq0_r[j][c] <= qm[71:40];
          spp_r[j][c] <= sp_r[j][c];
          // Correction and subtraction from one.
          qk  = 41'(sq0_r[j][c]) * 41'(ppef_pkg::K_TAB[c][j]);
          rem = spp_r[j][c] - qk[31:0];
          m   = (rem >= 32'(ppef_pkg::K_TAB[c][j])) ? sq0_r[j][c] + 32'd1 : sq0_r[j][c];
          srr_r[j][c] <= (m >= 32'(ppef_pkg::ONE_Q30)) ? 31'd0
                                                       : 31'(ppef_pkg::ONE_Q30[31:0] - m);
        end
      end
    end
  end

  // Cotangent denominator and radial preparation.
  logic [63:0] s_r, cden_r, dd_r, pl_r, ph_r, d3_r, rden_r;
  logic [30:0] cc_r, cc2_r;

  // Divider operand selection.
  logic [63:0]  ra;
  logic [127:0] rnum;
  logic [63:0]  d1_hi, d1_lo, d1_den, d2_hi, d2_lo, d2_den, q1, q2;

  always_comb begin
    ra   = (64'd1 << 32) - 64'(side_r[63].d);
    rnum = 128'(ra) << (GB + 32);
    if (mode_r) begin
      d1_hi  = ra >> 32;
      d1_lo  = ra << 32;
      d1_den = 64'(side_r[63].d) + 64'(eps_r);
      d2_hi  = rnum[127:64];
      d2_lo  = rnum[63:0];
      d2_den = rden_r;
    end else begin
      d1_hi  = 64'(cc2_r);
      d1_lo  = '0;
      d1_den = cden_r;
      d2_hi  = ppef_pkg::ONE_Q30;
      d2_lo  = '0;
      d2_den = cden_r;
    end
  end

  ppef_div u_div_e (.clk(clk), .en(adv), .hi(d1_hi), .lo(d1_lo), .den(d1_den), .q(q1));
  ppef_div u_div_f (.clk(clk), .en(adv), .hi(d2_hi), .lo(d2_lo), .den(d2_den), .q(q2));

  // Post-division cotangent path.
  logic [63:0]  pos_r, ww00_r, ww01_r, ww11_r;
  logic [127:0] pw_r;
  logic         ce2_neg_r, ce3_neg_r, ce4_neg_r;
  logic [63:0]  ce2_mag_r, ce3_mag_r, ce4_mag_r;
  logic [64:0]  kl_r, kh_r;
  logic [63:0]  kw_r;
  // Post-division radial path.
  logic [49:0]  rp00_r;
  logic [48:0]  rp01_r;
  logic [47:0]  rp11_r;
  logic [63:0]  fr1_r, fr2_r, fr3_r, fr4_r, re2_r, re3_r, re4_r;
  // Merged scalars.
  logic         m_eneg_r, m_fneg_r;
  logic [63:0]  m_emag_r, m_fmag_r;
  logic [81:0]  fp_r [3];

  always_ff @(posedge clk) begin
    logic [63:0]  q1c, w2, kw, rr;
    logic [127:0] wsh;
    logic [96:0]  kq;
    logic [97:0]  rsum;
    logic [63:0]  esh;
    logic [32:0]  epk;
    ppef_pkg::side_t sv;
    if (adv) begin
      // Energy packing for the beat leaving the mode merge.
      esh = m_emag_r >> (32 - OUT_FRAC_BITS);
      epk = ppef_pkg::pack32(m_eneg_r, esh);

      // Side data shift line with values filled in at their stages.
      side_r[0] <= side_in;
      for (int k = 1; k < LAST; k++) begin
        sv = side_r[k-1];
        if (k == ppef_pkg::STG_SUM) begin
          sv.far  = 64'(sum_c) >= (64'd1 << (2 * IN_FRAC_BITS));
          sv.zero = (sum_c == '0);
        end
        if (k == ppef_pkg::STG_D) sv.d = sqr_r[31][31:0];
        if (k == ppef_pkg::STG_T) sv.t = t_c;
        if (k == ppef_pkg::STG_U) sv.u = tt_r[65:34];
        if (k == ppef_pkg::STG_EN) begin
          sv.en   = epk[31:0];
          sv.esat = epk[32];
          sv.fneg = m_fneg_r;
        end
        side_r[k] <= sv;
      end

      for (int i = 0; i < 3; i++) sq_r[i] <= 35'(side_r[0].ax[i]) * 35'(side_r[0].ax[i]);
      sum_r <= sum_c;

      sqv_r <= sqv_nxt;
      sqr_r <= sqr_nxt;

      tprod_r <= 64'(sqr_r[31][31:0]) * 64'(ppef_pkg::HALF_PI_Q31);
      tt_r <= 66'(t_c) * 66'(t_c);

      // Cotangent denominator: eps + t * S(u).
      s_r    <= 64'(side_r[61].t) * 64'(srr_r[7][0]);
      cc_r   <= srr_r[7][1];
      cden_r <= s_r + (64'(eps_r) << 30);
      cc2_r  <= cc_r;

      // Radial: d cubed and its denominator.
      dd_r   <= 64'(side_r[59].d) * 64'(side_r[59].d);
      pl_r   <= 64'(dd_r[31:0]) * 64'(side_r[60].d);
      ph_r   <= 64'(dd_r[63:32]) * 64'(side_r[60].d);
      d3_r   <= ph_r + (pl_r >> 32);
      rden_r <= (d3_r >> 1) + (64'(eps_r) << 31);

      // Cotangent energy and the square of 1/den.
      q1c    = (q1 > ppef_pkg::Q_LIM) ? ppef_pkg::Q_LIM : q1;
      pos_r  <= q1c + 64'(side_r[ppef_pkg::STG_Q].t);
      ww00_r <= 64'(q2[31:0]) * 64'(q2[31:0]);
      ww01_r <= 64'(q2[31:0]) * 64'(q2[63:32]);
      ww11_r <= 64'(q2[63:32]) * 64'(q2[63:32]);

      pw_r <= {ww11_r, 64'd0} + {31'd0, ww01_r, 33'd0} + {64'd0, ww00_r};
      ce2_neg_r <= pos_r < 64'(ppef_pkg::HALF_PI_Q32);
      ce2_mag_r <= (pos_r < 64'(ppef_pkg::HALF_PI_Q32)) ? 64'(ppef_pkg::HALF_PI_Q32) - pos_r
                                                          : pos_r - 64'(ppef_pkg::HALF_PI_Q32);

      wsh = pw_r >> (64 - GB);
      w2  = ((pw_r >> (128 - GB)) != '0) ? '1 : wsh[63:0];
      kl_r <= 65'(w2[31:0]) * 65'(ppef_pkg::HALF_PI_Q32);
      kh_r <= 65'(w2[63:32]) * 65'(ppef_pkg::HALF_PI_Q32);
      ce3_neg_r <= ce2_neg_r;
      ce3_mag_r <= ce2_mag_r;

      kq = {kh_r[64:0], 32'd0} + 97'(kl_r);
      kw = kq[96] ? ppef_pkg::MAG_LIM : kq[95:32];
      kw_r <= (kw > ppef_pkg::MAG_LIM) ? ppef_pkg::MAG_LIM : kw;
      ce4_neg_r <= ce3_neg_r;
      ce4_mag_r <= ce3_mag_r;

      // Radial energy square and force clamp.
      rr     = (q1 > ppef_pkg::R_LIM) ? ppef_pkg::R_LIM : q1;
      rp00_r <= 50'(rr[24:0]) * 50'(rr[24:0]);
      rp01_r <= 49'(rr[24:0]) * 49'(rr[48:25]);
      rp11_r <= 48'(rr[48:25]) * 48'(rr[48:25]);
      fr1_r  <= (q2 > ppef_pkg::MAG_LIM) ? ppef_pkg::MAG_LIM : q2;

      rsum = {rp11_r, 50'd0} + {23'd0, rp01_r, 26'd0} + {48'd0, rp00_r};
      re2_r <= rsum[95:32];
      fr2_r <= fr1_r;
      re3_r <= re2_r;
      fr3_r <= fr2_r;
      re4_r <= re3_r;
      fr4_r <= fr3_r;

      // Mode merge.
      if (mode_r) begin
        m_eneg_r <= 1'b0;
        m_emag_r <= re4_r;
        m_fneg_r <= 1'b1;
        m_fmag_r <= fr4_r;
      end else begin
        m_eneg_r <= ce4_neg_r;
        m_emag_r <= ce4_mag_r;
        m_fneg_r <= (kw_r >= KG);
        m_fmag_r <= (kw_r >= KG) ? kw_r - KG : KG - kw_r;
      end

      // Force numerators.
      for (int i = 0; i < 3; i++)
        fp_r[i] <= 82'(m_fmag_r) * 82'(side_r[ppef_pkg::STG_MRG].ax[i]);
    end
  end

  // Force component dividers: |f| * |disp| / d.
  logic [63:0] fq [3];
  for (genvar g = 0; g < 3; g++) begin : g_fdiv
    ppef_div u_div (
      .clk (clk),
      .en  (adv),
      .hi  (64'(fp_r[g][81:64])),
      .lo  (fp_r[g][63:0]),
      .den (64'(side_r[ppef_pkg::STG_EN].d)),
      .q   (fq[g])
    );
  end

  // Output register.
  logic [127:0] out_data_r;
  logic [1:0]   out_user_r;

  always_ff @(posedge clk) begin
    ppef_pkg::side_t sd;
    logic [32:0] fpk;
    logic        sat;
    logic [95:0] fv;
    if (adv) begin
      sd  = side_r[ppef_pkg::STG_FQ];
      sat = sd.esat;
      for (int i = 0; i < 3; i++) begin
        fpk = ppef_pkg::pack32((sd.fneg != sd.xneg[i]) && (fq[i] != '0), fq[i]);
        fv[32*i +: 32] = fpk[31:0];
        sat = sat | fpk[32];
      end
      if (sd.far) begin
        out_data_r <= '0;
        out_user_r <= ppef_pkg::STAT_FAR;
      end else if (sd.zero) begin
        out_data_r <= {96'd0, sd.en};
        out_user_r <= ppef_pkg::STAT_ZERO;
      end else begin
        out_data_r <= {fv, sd.en};
        out_user_r <= sat ? ppef_pkg::STAT_SAT : ppef_pkg::STAT_OK;
      end
    end
  end

  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;

endmodule
`default_nettype wire

// ----- design/ppef_chk.sv -----
// Port-level checker for the pair energy and force block, bound to the top level.
`default_nettype none
module ppef_chk (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [127:0] out_tdata,
  input wire logic [1:0]   out_tuser
);

  // A stalled output beat holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output beat changed while stalled");

  // An empty output register never blocks the input side.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // Beyond cutoff every value field is zero.
  a_far: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ppef_pkg::STAT_FAR |-> out_tdata == '0)
    else $error("nonzero data beyond cutoff");

  // Zero displacement carries no force.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ppef_pkg::STAT_ZERO |-> out_tdata[127:32] == '0)
    else $error("force on zero displacement");

endmodule

bind particle_pair_energy_force ppef_chk u_ppef_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

// ----- test/particle_pair_energy_force_test.sv -----
// Self-checking testbench for the pair energy and force kernel.
`timescale 1ns / 100ps
`default_nettype none
module particle_pair_energy_force_test;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 260;
  localparam int RANDOM_ITEMS   = 700;

  typedef struct packed {
    logic signed [31:0] energy;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic [1:0]         status;
  } pair_result_t;

  typedef struct {
    int           dx;
    int           dy;
    int           dz;
    bit           typed;
    pair_result_t res;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [55:0]  in_tdata = '0;     // disp_x, disp_y, disp_z, zero fill
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;         // energy, force_x, force_y, force_z
  logic [1:0]   out_tuser;         // status
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  // Model copy of the registers.
  bit        mode_radial = 1'b0;
  bit [15:0] guard_eps = 16'd4295;

  // Side info that travels with the beat being offered on the input.
  bit           cur_typed = 1'b0;
  pair_result_t cur_fixed = '0;

  pair_result_t pending_results[$];
  int           error_count = 0;
  int           idle_cycles = 0;
  int           send_gap_max = 0;
  int           recv_stall_max = 0;

  particle_pair_energy_force u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #1 clk = ~clk;

  // Wide multiply and saturating 128-by-64 divide.
  function automatic bit [127:0] wide_mul(bit [63:0] a, bit [63:0] b);
    return {64'd0, a} * {64'd0, b};
  endfunction

  function automatic bit [63:0] sat_div(bit [63:0] hi, bit [63:0] lo, bit [63:0] den);
    bit [127:0] q;
    if (hi >= den) return '1;
    q = {hi, lo} / {64'd0, den};
    return q[63:0];
  endfunction

  function automatic bit [63:0] floor_sqrt(bit [63:0] v);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Horner evaluation of the sine or cosine Taylor series in Q30.
  function automatic bit [63:0] trig_series(bit [63:0] u, bit cosine);
    bit [63:0] r, m, k;
    r = 64'd1 << 30;
    for (int n = 16; n >= 2; n -= 2) begin
      k = cosine ? 64'((n - 1) * n) : 64'(n * (n + 1));
      m = ((u * r) >> 30) / k;
      r = (m >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - m;
    end
    return r;
  endfunction

  function automatic bit [31:0] clamp32(bit neg, bit [63:0] mag, inout bit sat);
    if (!neg) begin
      if (mag > 64'h7FFF_FFFF) begin
        sat = 1'b1;
        return 32'h7FFF_FFFF;
      end
      return mag[31:0];
    end
    if (mag > 64'h8000_0000) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return 32'd0 - mag[31:0];
  endfunction

  // Predicts energy, force and status for one displacement.
  function automatic pair_result_t predict_pair(bit [17:0] comp [3]);
    pair_result_t res;
    bit [63:0] mag [3];
    bit        neg [3];
    bit [63:0] sum, d, emag, fmag, eps, t, u, s, c, den, q, pos, w, w2, kw, kg;
    bit [63:0] a, r, d3, qf;
    bit [127:0] p;
    bit        eneg, fneg, sat, zero;
    bit [31:0] fv [3];
    res = '0;
    sum = 0;
    sat = 1'b0;
    eps = {48'd0, guard_eps};
    for (int i = 0; i < 3; i++) begin
      neg[i] = comp[i][17];
      mag[i] = neg[i] ? 64'h40000 - {46'd0, comp[i]} : {46'd0, comp[i]};
      sum += mag[i] * mag[i];
    end
    if (sum >= (64'd1 << 32)) begin
      res.status = ppef_pkg::STAT_FAR;
      return res;
    end
    zero = (sum == 0);
    d = floor_sqrt(sum << 32);
    if (!mode_radial) begin
      t = (d * 64'(ppef_pkg::HALF_PI_Q31)) >> 31;
      p = wide_mul(t, t);
      u = (p[127:64] << 30) | (p[63:0] >> 34);
      s = t * trig_series(u, 1'b0);
      c = trig_series(u, 1'b1);
      den = s + (eps << 30);
      q = sat_div(c, 0, den);
      if (q > (64'd1 << 62)) q = 64'd1 << 62;
      pos = q + t;
      eneg = pos < 64'(ppef_pkg::HALF_PI_Q32);
      emag = eneg ? 64'(ppef_pkg::HALF_PI_Q32) - pos : pos - 64'(ppef_pkg::HALF_PI_Q32);
      w = sat_div(64'd1 << 30, 0, den);
      p = wide_mul(w, w);
      w2 = (p[127:96] != 0) ? '1 : p[95:32];
      p = wide_mul(w2, 64'(ppef_pkg::HALF_PI_Q32));
      kw = (p[127:96] != 0) ? (64'd1 << 63) : p[95:32];
      if (kw > (64'd1 << 63)) kw = 64'd1 << 63;
      kg = 64'(ppef_pkg::HALF_PI_Q32);
      fneg = kw >= kg;
      fmag = fneg ? kw - kg : kg - kw;
    end else begin
      a = (64'd1 << 32) - d;
      r = sat_div(a >> 32, a << 32, d + eps);
      if (r > (64'd1 << 48)) r = 64'd1 << 48;
      p = wide_mul(r, r);
      emag = p[95:32];
      eneg = 1'b0;
      p = wide_mul(d * d, d);
      d3 = p[95:32];
      den = (d3 >> 1) + (eps << 31);
      fmag = sat_div(a, 0, den);
      if (fmag > (64'd1 << 63)) fmag = 64'd1 << 63;
      fneg = 1'b1;
    end
    // Internal energy is Q32; the output keeps 16 fraction bits.
    res.energy = clamp32(eneg, emag >> 16, sat);
    for (int i = 0; i < 3; i++) begin
      fv[i] = 0;
      if (!zero) begin
        qf = 0;
        if (mag[i] != 0) begin
          p = wide_mul(fmag, mag[i]);
          qf = sat_div(p[127:64], p[63:0], d);
        end
        fv[i] = clamp32((fneg != neg[i]) && (qf != 0), qf, sat);
      end
    end
    res.force_x = fv[0];
    res.force_y = fv[1];
    res.force_z = fv[2];
    res.status = zero ? ppef_pkg::STAT_ZERO : (sat ? ppef_pkg::STAT_SAT : ppef_pkg::STAT_OK);
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h", field, got, want);
    error_count++;
  endtask

  // Prediction, checking and watchdog, all on the rising edge.
  always @(posedge clk) begin
    bit [17:0]    comp [3];
    pair_result_t want;
    pair_result_t got;
    bit           moved;
    moved = 1'b0;
    if (rst_n && in_tvalid && in_tready) begin
      moved = 1'b1;
      comp[0] = in_tdata[17:0];
      comp[1] = in_tdata[35:18];
      comp[2] = in_tdata[53:36];
      pending_results.push_back(cur_typed ? cur_fixed : predict_pair(comp));
    end
    if (rst_n && out_tvalid && out_tready) begin
      moved = 1'b1;
      got.energy  = out_tdata[31:0];
      got.force_x = out_tdata[63:32];
      got.force_y = out_tdata[95:64];
      got.force_z = out_tdata[127:96];
      got.status  = out_tuser;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", got.energy, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (got.energy !== want.energy) report_mismatch("energy", got.energy, want.energy);
        if (got.force_x !== want.force_x)
          report_mismatch("force_x", got.force_x, want.force_x);
        if (got.force_y !== want.force_y)
          report_mismatch("force_y", got.force_y, want.force_y);
        if (got.force_z !== want.force_z)
          report_mismatch("force_z", got.force_z, want.force_z);
        if (got.status !== want.status)
          report_mismatch("status", {30'd0, got.status}, {30'd0, want.status});
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random stalls before each beat is taken.
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      n = $urandom_range(0, recv_stall_max);
      if (n > 0) begin
        out_tready = 1'b0;
        repeat (n) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Register write: setup cycle, then access cycle.
  task automatic write_reg(logic reg_sel, logic [31:0] value);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = {reg_sel, 2'b00};
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    if (reg_sel == ppef_pkg::REG_MODE) mode_radial = value[0];
    else guard_eps = value[15:0];
  endtask

  // Offer one displacement beat after a random gap; returns at a falling edge.
  task automatic send_pair(int dx, int dy, int dz, bit typed, pair_result_t fixed);
    int n;
    n = $urandom_range(0, send_gap_max);
    if (n > 0) begin
      in_tvalid = 1'b0;
      repeat (n) @(negedge clk);
    end
    in_tdata = {2'b00, 18'(dz), 18'(dy), 18'(dx)};
    cur_typed = typed;
    cur_fixed = fixed;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Random displacement: mostly inside the cutoff, with tiny, axis and full-range mixes.
  task automatic send_random_pair();
    int kind;
    int c [3];
    kind = $urandom_range(0, 99);
    for (int i = 0; i < 3; i++) begin
      if (kind < 60)      c[i] = $urandom_range(0, 74000) - 37000;
      else if (kind < 75) c[i] = $urandom_range(0, 510) - 255;
      else if (kind < 85) c[i] = 0;
      else                c[i] = $urandom_range(0, 262143) - 131072;
    end
    if (kind >= 75 && kind < 85) c[$urandom_range(0, 2)] = $urandom_range(0, 131070) - 65535;
    send_pair(c[0], c[1], c[2], 1'b0, '0);
  endtask

  stim_row_t directed [$];
  pair_result_t far_res;

  initial begin
    int mode_list [6] = '{1, 0, 1, 0, 1, 0};
    int eps_list [6]  = '{1, 1, 65535, 65535, 4295, -1};
    far_res = '0;
    far_res.status = ppef_pkg::STAT_FAR;
    // Directed rows: zero, cutoff edge, field extremes and small distances.
    directed = '{
      '{0, 0, 0, 1'b0, '0},
      '{65536, 0, 0, 1'b1, far_res},
      '{0, -65536, 0, 1'b1, far_res},
      '{131071, 131071, 131071, 1'b1, far_res},
      '{-131072, -131072, -131072, 1'b1, far_res},
      '{-131072, 0, 0, 1'b1, far_res},
      '{37838, 37838, 37838, 1'b1, far_res},
      '{65535, 0, 0, 1'b0, '0},
      '{0, -65535, 0, 1'b0, '0},
      '{0, 0, 65535, 1'b0, '0},
      '{1, 0, 0, 1'b0, '0},
      '{-1, -1, -1, 1'b0, '0},
      '{0, 0, -1, 1'b0, '0},
      '{37837, -37837, 37837, 1'b0, '0},
      '{32768, 0, 0, 1'b0, '0},
      '{-20000, 30000, -10000, 1'b0, '0},
      '{21845, 43690, -10922, 1'b0, '0},
      '{256, -256, 256, 1'b0, '0}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows under reset settings, back to back with no stalls.
    foreach (directed[i])
      send_pair(directed[i].dx, directed[i].dy, directed[i].dz,
                directed[i].typed, directed[i].res);
    wait_drained();

    // Random phases across the register extremes; every phase ends fully drained.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(ppef_pkg::REG_MODE, {$urandom_range(0, 32'h7FFF) << 1} | 32'(mode_list[ph]));
      write_reg(ppef_pkg::REG_EPS, (eps_list[ph] < 0) ? $urandom
                                   : {$urandom_range(0, 65535), 16'd0} | 32'(eps_list[ph]));
      send_gap_max = (ph % 3 == 0) ? 0 : 18;
      recv_stall_max = (ph % 2 == 0) ? 18 : 0;
      for (int k = 0; k < RANDOM_ITEMS / 6; k++) send_random_pair();
      // Also send the untyped directed rows again, predicted in the current mode.
      foreach (directed[i])
        if (!directed[i].typed) send_pair(directed[i].dx, directed[i].dy, directed[i].dz,
                                          1'b0, '0);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
